FILE: src/sab_pkg.sv
package sab_pkg;

	localparam int unsigned ValueWidth = 32;

	typedef logic signed [ValueWidth-1:0] value_t;

	// controller to datapath
	typedef struct packed {
		logic ins;      // insert the incoming word into the sorted cells
		logic set_drop; // incoming word dropped, store full
		logic shift;    // pop the smallest cell toward the output
		logic clr_drop; // end of run, forget the overflow mark
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;     // every cell holds a word
		logic last;     // the head cell is the final one of the run
	} sts_t;

endpackage

FILE: src/sab_if.sv
interface sab_in_if import sab_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	logic   last_item;

	modport source(output valid, value, last_item, input ready);
	modport sink(input valid, value, last_item, output ready);
endinterface

interface sab_out_if import sab_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t sorted_value;
	logic   last_result;
	logic   overflow;

	modport source(output valid, sorted_value, last_result, overflow, input ready);
	modport sink(input valid, sorted_value, last_result, overflow, output ready);
endinterface

FILE: src/sort_ascending_buffer.sv
// Sorting buffer for signed 32-bit words.
// Input channel "items": one word per handshake, value plus last_item, which
// marks the final word of a set. Output channel "results": the set in
// ascending order, last_result on its final word, overflow on every word of a
// run in which words beyond CAPACITY were dropped (the marked word too when
// the buffer was already full).
// Loading accepts a new word on every handshake, placing each straight into
// its sorted position in a row of CAPACITY compare-and-shift cells.
// The first result is offered the cycle after the marked word is accepted;
// results then leave at one per cycle while ready is high, popped from the
// head cell.
// While results are offered no input is taken; a stalled receiver simply
// holds the head word and the run resumes when ready returns.
// Reset empties all cells and clears the overflow mark; the block then
// accepts input at once.
module sort_ascending_buffer import sab_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input logic clk,
	input logic arst_n,
	sab_in_if.sink    items,
	sab_out_if.source results
);

	cmd_t cmd;
	sts_t sts;

	sab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last_item),
		.out_ready (results.ready),
		.sts       (sts),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.cmd       (cmd)
	);

	sab_cells #(
		.CAPACITY (CAPACITY)
	) u_cells (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (items.value),
		.sts        (sts),
		.head_value (results.sorted_value),
		.overflow   (results.overflow)
	);

	assign results.last_result = sts.last;

	// never load and emit together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && results.valid))
		else $error("load and emit overlap");

	// a marked word starts the run in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.last_item) |=> results.valid)
		else $error("run did not start after marked word");

	// the final result returns the block to loading
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last_result) |=> items.ready)
		else $error("block not ready after run");

	// an emptied buffer holds no pending overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last_result) |=> !results.overflow)
		else $error("overflow mark survived the run");

endmodule

FILE: src/sab_ctrl.sv
module sab_ctrl import sab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	input  sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	localparam logic StLoad = 1'b0;
	localparam logic StEmit = 1'b1;

	logic state_q;
	logic load;

	assign in_ready  = (state_q == StLoad);
	assign out_valid = (state_q == StEmit);
	assign load      = in_ready && in_valid;

	// decode commands for the datapath
	always_comb begin
		cmd          = '0;
		cmd.ins      = load && !sts.full;
		cmd.set_drop = load && sts.full;
		cmd.shift    = out_valid && out_ready;
		cmd.clr_drop = out_valid && out_ready && sts.last;
	end

	// advance between collecting and emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
		end else begin
			unique case (state_q)
				StLoad: begin
					if (load && in_last) state_q <= StEmit;
				end
				StEmit: begin
					if (cmd.clr_drop) state_q <= StLoad;
				end
				default: state_q <= StLoad;
			endcase
		end
	end

endmodule

FILE: src/sab_cells.sv
module sab_cells import sab_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  value_t value,
	output sts_t   sts,
	output value_t head_value,
	output logic   overflow
);

	value_t cell_q [CAPACITY];
	logic   [CAPACITY-1:0] occ_q;
	logic   [CAPACITY-1:0] key;
	logic   drop_q;

	// a cell moves when it is empty or holds a larger word than the new one
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			key[i] = !occ_q[i] || (cell_q[i] > value);
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic   prev_key;
			logic   prev_occ;
			logic   next_occ;
			value_t prev_val;
			value_t next_val;

			if (g == 0) begin : g_first
				assign prev_key = 1'b0;
				assign prev_occ = 1'b1;
				assign prev_val = '0;
			end else begin : g_mid
				assign prev_key = key[g-1];
				assign prev_occ = occ_q[g-1];
				assign prev_val = cell_q[g-1];
			end

			if (g == CAPACITY - 1) begin : g_tail
				assign next_occ = 1'b0;
				assign next_val = '0;
			end else begin : g_body
				assign next_occ = occ_q[g+1];
				assign next_val = cell_q[g+1];
			end

			// insert: take the new word or the left neighbor; emit: take the right one
			always_ff @(posedge clk) begin
				if (cmd.shift) begin
					cell_q[g] <= next_val;
				end else if (cmd.ins && key[g]) begin
					cell_q[g] <= prev_key ? prev_val : value;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					occ_q[g] <= 1'b0;
				end else if (cmd.shift) begin
					occ_q[g] <= next_occ;
				end else if (cmd.ins) begin
					occ_q[g] <= occ_q[g] | prev_occ;
				end
			end
		end
	endgenerate

	// hold the overflow mark for the whole run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd.clr_drop) begin
			drop_q <= 1'b0;
		end else if (cmd.set_drop) begin
			drop_q <= 1'b1;
		end
	end

	always_comb begin
		sts      = '0;
		sts.full = occ_q[CAPACITY-1];
		sts.last = !occ_q[1];
	end

	assign head_value = cell_q[0];
	assign overflow   = drop_q;

endmodule
